[rtl/snfr_pkg.sv]
// ----------------------------------------------------------------------------
// snfr_pkg
// Shared types and constants for the sensor node frame responder.
// ----------------------------------------------------------------------------
package snfr_pkg;

    localparam logic [7:0] HDR         = 8'hAA;
    localparam logic [7:0] OP_SEND_REQ = 8'h01;
    localparam logic [7:0] OP_SEND_OK  = 8'h02;
    localparam logic [7:0] OP_DATA     = 8'h03;
    localparam logic [7:0] OP_DATA_ACK = 8'h04;
    localparam logic [7:0] OP_CFG_REQ  = 8'h05;
    localparam logic [7:0] OP_CFG_SAME = 8'h06;
    localparam logic [7:0] OP_CFG_DATA = 8'h07;

    localparam int WORD_W         = 32;
    localparam int CFG_REGS       = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int WORDS_PER_NODE = 4;
    localparam int MAX_NODES      = 2;

    localparam logic [15:0] NODE_ID [MAX_NODES] = '{16'h0001, 16'h0002};

    // frame fill positions (bytes already held)
    localparam int FILL_W = 4;
    localparam logic [FILL_W-1:0] FILL_EMPTY = 4'd0;
    localparam logic [FILL_W-1:0] FILL_ID_HI = 4'd1;
    localparam logic [FILL_W-1:0] FILL_ID_LO = 4'd2;
    localparam logic [FILL_W-1:0] FILL_OP    = 4'd3;
    localparam logic [FILL_W-1:0] FILL_LAST  = 4'd15;

    // reply byte positions
    localparam int BCNT_W = 5;
    localparam logic [BCNT_W-1:0] BCNT_HDR        = 5'd0;
    localparam logic [BCNT_W-1:0] BCNT_ID_HI      = 5'd1;
    localparam logic [BCNT_W-1:0] BCNT_ID_LO      = 5'd2;
    localparam logic [BCNT_W-1:0] BCNT_OP         = 5'd3;
    localparam logic [BCNT_W-1:0] BCNT_SHORT_LAST = 5'd3;
    localparam logic [BCNT_W-1:0] BCNT_LONG_LAST  = 5'd19;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [CFG_REGS-1:0][WORD_W-1:0] cfg_words_t;
    typedef logic [WORDS_PER_NODE-1:0][WORD_W-1:0] node_words_t;

    typedef enum logic [1:0] {
        JOB_SEND,
        JOB_DATA,
        JOB_CFG
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic              node;
        logic [7:0]        id_hi;
        logic [7:0]        id_lo;
        logic [WORD_W-1:0] hum;
        logic [WORD_W-1:0] temp;
        logic [WORD_W-1:0] soil;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

[rtl/snfr_front.sv]
// ----------------------------------------------------------------------------
// snfr_front
// Header hunt, frame collection and classification into reply jobs.
// ----------------------------------------------------------------------------
module snfr_front #(
    parameter int NODE_COUNT = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          push,
    output snfr_pkg::job_t push_job
);
    import snfr_pkg::*;

    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [7:0]          id_hi_reg, id_lo_reg, op_reg;
    logic [3*WORD_W-1:0] data_reg, data_next;
    logic                accept;
    logic                close_short, close_long, do_close;
    logic                node_hit;
    logic                node_idx;
    logic                kind_ok;
    job_kind_t           kind;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign data_next = {rx_byte, data_reg[3*WORD_W-1:8]};

    assign close_short = (fill_reg == FILL_OP) &&
                         ((rx_byte == OP_SEND_REQ) || (rx_byte == OP_CFG_REQ));
    assign close_long  = (fill_reg == FILL_LAST);
    assign do_close    = close_short || close_long;

    always_comb
    begin
        node_hit = 1'b0;
        node_idx = 1'b0;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            if (!node_hit && ({id_hi_reg, id_lo_reg} == NODE_ID[n]))
            begin
                node_hit = 1'b1;
                node_idx = 1'(n);
            end
        end
    end

    always_comb
    begin
        kind    = JOB_SEND;
        kind_ok = 1'b0;
        if (close_short)
        begin
            kind_ok = 1'b1;
            kind    = (rx_byte == OP_SEND_REQ) ? JOB_SEND : JOB_CFG;
        end
        else if (close_long && (op_reg == OP_DATA))
        begin
            kind_ok = 1'b1;
            kind    = JOB_DATA;
        end
    end

    assign push           = accept && do_close && kind_ok && node_hit;
    assign push_job.kind  = kind;
    assign push_job.node  = node_idx;
    assign push_job.id_hi = id_hi_reg;
    assign push_job.id_lo = id_lo_reg;
    assign push_job.hum   = data_next[WORD_W-1:0];
    assign push_job.temp  = data_next[2*WORD_W-1:WORD_W];
    assign push_job.soil  = data_next[3*WORD_W-1:2*WORD_W];

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (fill_reg == FILL_EMPTY)
                fill_next = (rx_byte == HDR) ? FILL_ID_HI : FILL_EMPTY;
            else if (do_close)
                fill_next = FILL_EMPTY;
            else
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= FILL_EMPTY;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (fill_reg)
                FILL_EMPTY: ;
                FILL_ID_HI: id_hi_reg <= rx_byte;
                FILL_ID_LO: id_lo_reg <= rx_byte;
                FILL_OP:    op_reg    <= rx_byte;
                default:    data_reg  <= data_next;
            endcase
        end
    end

endmodule

[rtl/snfr_queue.sv]
// ----------------------------------------------------------------------------
// snfr_queue
// Short job queue between frame front end and reply back end.
// ----------------------------------------------------------------------------
module snfr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  snfr_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output snfr_pkg::job_t head_job
);
    import snfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/snfr_back.sv]
// ----------------------------------------------------------------------------
// snfr_back
// Reply sequencer: threshold cache check, byte emission, output register.
// ----------------------------------------------------------------------------
module snfr_back #(
    parameter int NODE_COUNT = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  snfr_pkg::cfg_words_t  cfg_words,
    input  logic                  head_valid,
    input  snfr_pkg::job_t        head_job,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            tx_byte,
    output logic                  tx_valid,
    output logic                  tx_last,
    output logic                  report_valid,
    output logic                  report_node,
    output logic [31:0]           report_hum,
    output logic [31:0]           report_temp,
    output logic [31:0]           report_soil
);
    import snfr_pkg::*;

    back_state_t       state_reg, state_next;
    logic [BCNT_W-1:0] cnt_reg;
    logic [BCNT_W-1:0] last_reg;
    logic [7:0]        op_reg;
    job_t              job_reg;

    node_words_t       cache_reg [NODE_COUNT];
    logic [NODE_COUNT-1:0] cache_valid_reg;

    node_words_t       head_cfg;
    logic              head_same;
    logic              head_reload;
    logic [7:0]        head_op;
    logic [BCNT_W-1:0] head_last;

    logic              out_free, advance, at_last;
    logic [2:0]        wsel_full;
    logic [1:0]        wsel;
    logic [WORD_W-1:0] sel_word;

    logic [7:0]        byte_val;
    logic              last_val, rep_val;

    logic              out_valid_reg;
    logic [7:0]        tx_byte_reg;
    logic              tx_last_reg, rep_valid_reg, rep_node_reg;
    logic [WORD_W-1:0] rep_hum_reg, rep_temp_reg, rep_soil_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = (state_reg == BK_RUN) && out_free;
    assign at_last  = (cnt_reg == last_reg);
    assign pop      = head_valid && ((state_reg == BK_IDLE) || (advance && at_last));

    // cache check for the job at the head of the queue
    always_comb
    begin
        head_cfg  = '0;
        head_same = 1'b0;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            if (head_job.node == 1'(n))
            begin
                for (int w = 0; w < WORDS_PER_NODE; w++)
                    head_cfg[w] = cfg_words[n * WORDS_PER_NODE + w];
                head_same = cache_valid_reg[n] && (cache_reg[n] == head_cfg);
            end
        end
    end

    always_comb
    begin
        head_reload = 1'b0;
        head_last   = BCNT_SHORT_LAST;
        case (head_job.kind)
            JOB_SEND: head_op = OP_SEND_OK;
            JOB_DATA: head_op = OP_DATA_ACK;
            JOB_CFG:
            begin
                if (head_same)
                    head_op = OP_CFG_SAME;
                else
                begin
                    head_op     = OP_CFG_DATA;
                    head_last   = BCNT_LONG_LAST;
                    head_reload = 1'b1;
                end
            end
            default: head_op = OP_SEND_OK;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (pop)
            state_next = BK_RUN;
        else if (advance && at_last)
            state_next = BK_IDLE;
    end

    // byte for the current reply position
    assign wsel_full = cnt_reg[4:2] - 3'd1;
    assign wsel      = wsel_full[1:0];

    always_comb
    begin
        sel_word = '0;
        for (int n = 0; n < NODE_COUNT; n++)
            for (int w = 0; w < WORDS_PER_NODE; w++)
                if ((job_reg.node == 1'(n)) && (wsel == 2'(w)))
                    sel_word = cfg_words[n * WORDS_PER_NODE + w];
    end

    always_comb
    begin
        case (cnt_reg)
            BCNT_HDR:   byte_val = HDR;
            BCNT_ID_HI: byte_val = job_reg.id_hi;
            BCNT_ID_LO: byte_val = job_reg.id_lo;
            BCNT_OP:    byte_val = op_reg;
            default:    byte_val = sel_word[{cnt_reg[1:0], 3'b000} +: 8];
        endcase
        last_val = at_last;
        rep_val  = (cnt_reg == BCNT_HDR) && (job_reg.kind == JOB_DATA);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            cnt_reg         <= '0;
            cache_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cnt_reg <= BCNT_HDR;
            else if (advance)
                cnt_reg <= cnt_reg + 1'b1;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            for (int n = 0; n < NODE_COUNT; n++)
                if (pop && head_reload && (head_job.node == 1'(n)))
                    cache_valid_reg[n] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head_job;
            op_reg   <= head_op;
            last_reg <= head_last;
        end
        for (int n = 0; n < NODE_COUNT; n++)
            if (pop && head_reload && (head_job.node == 1'(n)))
                cache_reg[n] <= head_cfg;
        if (advance)
        begin
            tx_byte_reg   <= byte_val;
            tx_last_reg   <= last_val;
            rep_valid_reg <= rep_val;
            rep_node_reg  <= rep_val ? job_reg.node : 1'b0;
            rep_hum_reg   <= rep_val ? job_reg.hum  : '0;
            rep_temp_reg  <= rep_val ? job_reg.temp : '0;
            rep_soil_reg  <= rep_val ? job_reg.soil : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign tx_valid     = out_valid_reg;
    assign tx_last      = tx_last_reg;
    assign report_valid = rep_valid_reg;
    assign report_node  = rep_node_reg;
    assign report_hum   = rep_hum_reg;
    assign report_temp  = rep_temp_reg;
    assign report_soil  = rep_soil_reg;

endmodule

[rtl/sensor_node_frame_responder.sv]
// ----------------------------------------------------------------------------
// sensor_node_frame_responder
// Byte-serial frame responder for a two-node sensor gateway.
// ----------------------------------------------------------------------------
// Received bytes enter at one per cycle while the queue is not full. A
// closed frame with a known node and a valid opcode becomes a reply job in
// a two-entry queue; the back end sends the reply at one byte per cycle
// while out_stall is low, through an output register (4 bytes, or 20 for a
// config data reply), popping the next job as the last byte is registered.
// The input stalls only while both queue entries hold waiting jobs, so the
// reply length sets the sustained rate (a 4-byte config request: 20 bytes).
// ----------------------------------------------------------------------------
module sensor_node_frame_responder #(
    parameter int NODE_COUNT = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    tx_byte,
    output logic                          tx_valid,
    output logic                          tx_last,
    output logic                          report_valid,
    output logic                          report_node,
    output logic [31:0]                   report_hum,
    output logic [31:0]                   report_temp,
    output logic [31:0]                   report_soil,
    input  logic                          cfg_we,
    input  logic [snfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [snfr_pkg::WORD_W-1:0]   cfg_data
);
    import snfr_pkg::*;

    cfg_words_t cfg_reg;
    logic       q_full, q_push, q_pop, q_valid;
    job_t       q_push_job, q_head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_data;
    end

    snfr_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_push_job)
    );

    snfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    snfr_back #(
        .NODE_COUNT(NODE_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_words    (cfg_reg),
        .head_valid   (q_valid),
        .head_job     (q_head_job),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .tx_last      (tx_last),
        .report_valid (report_valid),
        .report_node  (report_node),
        .report_hum   (report_hum),
        .report_temp  (report_temp),
        .report_soil  (report_soil)
    );

endmodule

[tb/snfr_reply_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snfr_reply_checker
// Watches the byte channels and the register port of the frame responder,
// predicts the reply bytes of every received item and checks them in order.
// ----------------------------------------------------------------------------
module snfr_reply_checker #(
    parameter int NODE_COUNT = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     tx_byte,
    input  logic                           tx_valid,
    input  logic                           tx_last,
    input  logic                           report_valid,
    input  logic                           report_node,
    input  logic [31:0]                    report_hum,
    input  logic [31:0]                    report_temp,
    input  logic [31:0]                    report_soil,
    input  logic                           cfg_we,
    input  logic [snfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [snfr_pkg::WORD_W-1:0]    cfg_data,
    output int                             fail_count,
    output int                             replies_due
);

    import snfr_pkg::*;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        tx_last;
        logic        report_valid;
        logic        report_node;
        logic [31:0] hum;
        logic [31:0] temp;
        logic [31:0] soil;
    } reply_t;

    reply_t      reply_q [$];
    logic [31:0] limit_word [CFG_REGS];
    logic [31:0] cache_word [CFG_REGS];
    logic        cache_ok [MAX_NODES];
    logic [7:0]  frame_buf [20];
    int          frame_fill;
    int          mismatch_cnt;

    // leftover expectations count against the run as well
    assign fail_count = mismatch_cnt + replies_due;

    function automatic reply_t reply_byte(input logic [7:0] b, input logic is_end);
        reply_t r;
        r          = '0;
        r.tx_byte  = b;
        r.tx_valid = 1'b1;
        r.tx_last  = is_end;
        return r;
    endfunction

    function automatic logic [31:0] le_word(input int pos);
        return {frame_buf[pos+3], frame_buf[pos+2], frame_buf[pos+1], frame_buf[pos]};
    endfunction

    // header byte (possibly carrying the report) plus the echoed node id
    task automatic push_head(input reply_t first);
        reply_q.push_back(first);
        reply_q.push_back(reply_byte(frame_buf[1], 1'b0));
        reply_q.push_back(reply_byte(frame_buf[2], 1'b0));
    endtask

    task automatic answer_frame(input int len);
        logic [15:0] id;
        logic [7:0]  op;
        logic        same;
        reply_t      r;
        int          node;
        int          base;
        int          i;
        int          j;
        id   = {frame_buf[1], frame_buf[2]};
        op   = frame_buf[3];
        node = -1;
        for (i = 0; i < NODE_COUNT && i < MAX_NODES; i++)
            if (node < 0 && NODE_ID[i] == id)
                node = i;
        if (node < 0)
            return;
        base = node * WORDS_PER_NODE;
        if (op == OP_SEND_REQ && len == 4) begin
            push_head(reply_byte(HDR, 1'b0));
            reply_q.push_back(reply_byte(OP_SEND_OK, 1'b1));
        end else if (op == OP_DATA && len == 16) begin
            r              = reply_byte(HDR, 1'b0);
            r.report_valid = 1'b1;
            r.report_node  = node[0];
            r.hum          = le_word(4);
            r.temp         = le_word(8);
            r.soil         = le_word(12);
            push_head(r);
            reply_q.push_back(reply_byte(OP_DATA_ACK, 1'b1));
        end else if (op == OP_CFG_REQ && len == 4) begin
            same = cache_ok[node];
            for (i = 0; i < WORDS_PER_NODE; i++)
                if (cache_word[base+i] != limit_word[base+i])
                    same = 1'b0;
            push_head(reply_byte(HDR, 1'b0));
            if (same) begin
                reply_q.push_back(reply_byte(OP_CFG_SAME, 1'b1));
            end else begin
                reply_q.push_back(reply_byte(OP_CFG_DATA, 1'b0));
                for (i = 0; i < WORDS_PER_NODE; i++) begin
                    for (j = 0; j < 4; j++)
                        reply_q.push_back(reply_byte(limit_word[base+i][8*j +: 8],
                                                     i == WORDS_PER_NODE - 1 && j == 3));
                    cache_word[base+i] = limit_word[base+i];
                end
                cache_ok[node] = 1'b1;
            end
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        if (frame_fill == 0 || frame_fill >= 20) begin
            // hunting for a header
            frame_fill = 0;
            if (b == HDR) begin
                frame_buf[0] = b;
                frame_fill   = 1;
            end
        end else begin
            frame_buf[frame_fill] = b;
            frame_fill++;
            if (frame_fill == 4) begin
                if (frame_buf[3] == OP_SEND_REQ || frame_buf[3] == OP_CFG_REQ) begin
                    frame_fill = 0;
                    answer_frame(4);
                end
            end else if (frame_fill == 16) begin
                frame_fill = 0;
                answer_frame(16);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        int     i;
        if (!rst_n) begin
            reply_q.delete();
            frame_fill   = 0;
            mismatch_cnt = 0;
            replies_due  = 0;
            for (i = 0; i < CFG_REGS; i++) begin
                limit_word[i] = '0;
                cache_word[i] = '0;
            end
            for (i = 0; i < MAX_NODES; i++)
                cache_ok[i] = 1'b0;
            for (i = 0; i < 20; i++)
                frame_buf[i] = '0;
        end else begin
            if (out_valid && !out_stall) begin
                if (reply_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: reply item, expected none, actual tx_byte %h",
                             $time, tx_byte);
                end else begin
                    want = reply_q.pop_front();
                    check_field("tx_byte",      32'(want.tx_byte),      32'(tx_byte));
                    check_field("tx_valid",     32'(want.tx_valid),     32'(tx_valid));
                    check_field("tx_last",      32'(want.tx_last),      32'(tx_last));
                    check_field("report_valid", 32'(want.report_valid), 32'(report_valid));
                    check_field("report_node",  32'(want.report_node),  32'(report_node));
                    check_field("report_hum",   want.hum,               report_hum);
                    check_field("report_temp",  want.temp,              report_temp);
                    check_field("report_soil",  want.soil,              report_soil);
                end
            end
            if (cfg_we)
                limit_word[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                take_rx_byte(rx_byte);
            replies_due = reply_q.size();
        end
    end

endmodule

[tb/sensor_node_frame_responder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_node_frame_responder_tb
// Feeds directed and random frames, noise and broken frames through the
// responder across several threshold settings, with random idling on both
// sides and one long output hold-off; a checker compares every reply item.
// ----------------------------------------------------------------------------
module sensor_node_frame_responder_tb;

    import snfr_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAD   = 40;
    localparam int PHASES      = 4;
    localparam int PHASE_BYTES = 80;

    typedef enum int {
        LIM_ZERO,
        LIM_ONES,
        LIM_RAND
    } limit_fill_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           tx_byte;
    logic                 tx_valid;
    logic                 tx_last;
    logic                 report_valid;
    logic                 report_node;
    logic [31:0]          report_hum;
    logic [31:0]          report_temp;
    logic [31:0]          report_soil;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    int fail_count;
    int replies_due;
    int cycle_cnt  = 0;
    int sent_bytes = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_gaps_on = 1'b0;
    bit hold_rx    = 1'b0;
    bit hold_taken = 1'b0;

    sensor_node_frame_responder #(
        .NODE_COUNT(2)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .tx_valid    (tx_valid),
        .tx_last     (tx_last),
        .report_valid(report_valid),
        .report_node (report_node),
        .report_hum  (report_hum),
        .report_temp (report_temp),
        .report_soil (report_soil),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    snfr_reply_checker #(
        .NODE_COUNT(2)
    ) reply_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .tx_valid    (tx_valid),
        .tx_last     (tx_last),
        .report_valid(report_valid),
        .report_node (report_node),
        .report_hum  (report_hum),
        .report_temp (report_temp),
        .report_soil (report_soil),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .replies_due (replies_due)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver side: random stall bursts, plus one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_rx && !hold_taken)
        begin
            hold_taken = 1'b1;
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            out_stall <= 1'b0;
        end
        else if (rx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // valid stays high from item to item unless a gap is taken
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_bytes++;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return NODE_ID[$urandom_range(0, MAX_NODES - 1)];
        return 16'($urandom);
    endfunction

    task automatic send_frame(input logic [15:0] id, input logic [7:0] op, input int len);
        int k;
        send_byte(HDR);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(op);
        for (k = 4; k < len; k++)
            send_byte(payload_byte());
    endtask

    task automatic random_frame();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            send_frame(pick_id(), OP_SEND_REQ, 4);
        else if (pick < 50)
            send_frame(pick_id(), OP_CFG_REQ, 4);
        else if (pick < 75)
            send_frame(pick_id(), OP_DATA, 16);
        else if (pick < 83)
            send_frame(pick_id(), 8'($urandom), 16);
        else if (pick < 91)
        begin
            // line noise
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                send_byte(8'($urandom));
        end
        else
        begin
            // header cut short; the next frame's bytes get swallowed into it
            n = $urandom_range(0, 2);
            send_byte(HDR);
            for (k = 0; k < n; k++)
                send_byte(8'($urandom));
        end
    endtask

    task automatic write_limits(input int first, input int upto, input limit_fill_t fill);
        int i;
        for (i = first; i <= upto; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            case (fill)
                LIM_ZERO: cfg_data <= '0;
                LIM_ONES: cfg_data <= '1;
                default:  cfg_data <= $urandom;
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (replies_due != 0) @(negedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    initial
    begin
        // data frame for node 1 with extreme readings
        logic [7:0] data_frame [16];
        int ph;
        int k;
        int start;

        data_frame = '{HDR, NODE_ID[1][15:8], NODE_ID[1][7:0], OP_DATA,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'h00, 8'h00, 8'h00,
                       8'h01, 8'h00, 8'h00, 8'h80};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_limits(0, CFG_REGS - 1, LIM_ZERO);

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_frame(NODE_ID[0], OP_SEND_REQ, 4);
        send_frame(NODE_ID[1], OP_CFG_REQ, 4);
        for (k = 0; k < 16; k++)
            send_byte(data_frame[k]);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
                hold_rx = 1'b1;
            start = sent_bytes;
            while (sent_bytes - start < PHASE_BYTES)
            begin
                if (ph == PHASES - 1)
                begin
                    tx_gaps_on = 1'b0;
                    rx_gaps_on = 1'b0;
                end
                else
                begin
                    tx_gaps_on = ($urandom_range(0, 3) != 0);
                    rx_gaps_on = ($urandom_range(0, 3) != 0);
                end
                random_frame();
            end
            wait_idle();
            case (ph)
                0: write_limits(0, CFG_REGS - 1, LIM_ONES);
                1: write_limits(0, CFG_REGS - 1, LIM_RAND);
                // node 1 only: node 0's cached words stay current
                2: write_limits(WORDS_PER_NODE, CFG_REGS - 1, LIM_RAND);
                default: ;
            endcase
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/snfr_pkg.sv
rtl/snfr_front.sv
rtl/snfr_queue.sv
rtl/snfr_back.sv
rtl/sensor_node_frame_responder.sv
tb/snfr_reply_checker.sv
tb/sensor_node_frame_responder_tb.sv
